[rtl/memory_lcd_line_packer_top_defines.svh]
// ----------------------------------------------------------------------------
// Memory-LCD line packer assertion macros
// Shared assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef MEMORY_LCD_LINE_PACKER_TOP_DEFINES_SVH
`define MEMORY_LCD_LINE_PACKER_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define MLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define MLP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[rtl/mlp_pkg.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer package
// Types, codes and helper functions shared by the packer modules.
// ----------------------------------------------------------------------------
package mlp_pkg;

    // Byte kinds on the result stream.
    localparam logic [1:0] KIND_CMD   = 2'd0;
    localparam logic [1:0] KIND_ADDR  = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;
    localparam logic [1:0] KIND_TRAIL = 2'd3;

    // Mode command bytes.
    localparam logic [7:0] CMD_COLOR = 8'b1000_0000;
    localparam logic [7:0] CMD_MONO  = 8'b1000_1000;

    // Register indexes on the configuration port.
    localparam int unsigned REG_AW = 3;
    localparam logic [REG_AW-1:0] REG_COLOR_MODE   = 3'd0;
    localparam logic [REG_AW-1:0] REG_MONO_CUTOFF  = 3'd1;
    localparam logic [REG_AW-1:0] REG_COLOR_CUTOFF = 3'd2;
    localparam logic [REG_AW-1:0] REG_MONO_INVERT  = 3'd3;
    localparam logic [REG_AW-1:0] REG_START_LINE   = 3'd4;

    // Results kept per item, and candidates before the cap.
    localparam int unsigned MAX_RES = 5;
    localparam int unsigned N_CAND  = 7;
    localparam int unsigned CNT_W   = 3;

    // Bits per group in each mode.
    localparam logic [4:0] GROUP_MONO  = 5'd8;
    localparam logic [4:0] GROUP_COLOR = 5'd24;
    localparam logic [4:0] BIT_MAX     = 5'd23;

    // Configuration register set.
    typedef struct packed {
        logic       color_mode;
        logic [7:0] mono_cutoff;
        logic [7:0] color_cutoff;
        logic       mono_invert;
        logic [7:0] start_line;
    } cfg_t;

    // One result byte.
    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
    } res_t;

    // All results of one item, entry 0 first.
    typedef struct packed {
        res_t [MAX_RES-1:0]  ent;
        logic [CNT_W-1:0]    cnt;
    } res_list_t;

    // Swap the first and third bit of every 3-bit group (red/blue flip).
    function automatic logic [23:0] rb_swap(input logic [23:0] d);
        logic [23:0] r;
        for (int g = 0; g < 8; g++) begin
            r[3*g]     = d[3*g + 2];
            r[3*g + 1] = d[3*g + 1];
            r[3*g + 2] = d[3*g];
        end
        return r;
    endfunction

endpackage

[rtl/mlp_cfg.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer configuration registers
// APB-style register file holding mode, cutoffs, inversion and start line.
// ----------------------------------------------------------------------------
module mlp_cfg (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output mlp_pkg::cfg_t cfg
);
    import mlp_pkg::*;

    cfg_t              cfg_reg;
    cfg_t              cfg_next;
    logic              wr_en;
    logic [REG_AW-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // Register write decode.
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_COLOR_MODE:   cfg_next.color_mode   = pwdata[0];
                REG_MONO_CUTOFF:  cfg_next.mono_cutoff  = pwdata[7:0];
                REG_COLOR_CUTOFF: cfg_next.color_cutoff = pwdata[7:0];
                REG_MONO_INVERT:  cfg_next.mono_invert  = pwdata[0];
                REG_START_LINE:   cfg_next.start_line   = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.color_mode   <= 1'b0;
            cfg_reg.mono_cutoff  <= 8'd128;
            cfg_reg.color_cutoff <= 8'd128;
            cfg_reg.mono_invert  <= 1'b0;
            cfg_reg.start_line   <= 8'd0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux.
    always_comb begin
        unique case (reg_idx)
            REG_COLOR_MODE:   prdata = {31'd0, cfg_reg.color_mode};
            REG_MONO_CUTOFF:  prdata = {24'd0, cfg_reg.mono_cutoff};
            REG_COLOR_CUTOFF: prdata = {24'd0, cfg_reg.color_cutoff};
            REG_MONO_INVERT:  prdata = {31'd0, cfg_reg.mono_invert};
            REG_START_LINE:   prdata = {24'd0, cfg_reg.start_line};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

[rtl/mlp_pack.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer bit packing stage
// Registers one input item, packs its bit and builds the list of its results.
// ----------------------------------------------------------------------------
module mlp_pack (
    input  logic               aclk,
    input  logic               aresetn,
    input  mlp_pkg::cfg_t      cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // [7:0] sample
    input  logic               s_tlast,   // line_end
    input  logic               s_tuser,   // [0] frame_end
    input  logic               ser_ready,
    output logic               list_vld,
    output mlp_pkg::res_list_t list
);
    import mlp_pkg::*;

    // Input register.
    logic       in_vld_reg, in_vld_next;
    logic [7:0] sample_reg;
    logic       line_end_reg;
    logic       frame_end_reg;

    // Packing state.
    logic [23:0] acc_reg, acc_next;
    logic [4:0]  bc_reg, bc_next;
    logic [7:0]  lc_reg, lc_next;
    logic        line_start_reg, line_start_next;
    logic        frame_start_reg, frame_start_next;

    logic        s_fire;
    logic        advance;

    // Working values.
    logic [7:0]  cutoff;
    logic [4:0]  group;
    logic [4:0]  bc_sat;
    logic [4:0]  bc_inc;
    logic [23:0] acc_set;
    logic        bit_set;
    logic        any_end;
    logic        emit;
    logic [7:0]  lc_cur;
    logic [23:0] swapped;
    logic [7:0]  mono_byte;
    res_t        cand [N_CAND];
    logic [N_CAND-1:0] cand_en;
    res_list_t   lst;

    assign s_fire   = s_tvalid && s_tready;
    assign advance  = in_vld_reg && ser_ready;
    assign s_tready = !in_vld_reg || ser_ready;
    assign list_vld = advance;
    assign list     = lst;

    // Input register valid tracking.
    always_comb begin
        in_vld_next = s_fire || (in_vld_reg && !advance);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_reg    <= s_tdata;
            line_end_reg  <= s_tlast;
            frame_end_reg <= s_tuser;
        end
    end

    // Bit packing of the held item.
    always_comb begin
        cutoff  = cfg.color_mode ? cfg.color_cutoff : cfg.mono_cutoff;
        group   = cfg.color_mode ? GROUP_COLOR : GROUP_MONO;
        bc_sat  = (bc_reg > BIT_MAX) ? BIT_MAX : bc_reg;
        bit_set = sample_reg >= cutoff;
        acc_set = acc_reg | (bit_set ? (24'h80_0000 >> bc_sat) : 24'd0);
        bc_inc  = bc_sat + 5'd1;
        any_end = line_end_reg || frame_end_reg;
        // A line end always flushes, since at least one bit is now held.
        emit    = (bc_inc >= group) || any_end;
        lc_cur  = frame_start_reg ? cfg.start_line : lc_reg;
        swapped = rb_swap(acc_set);
        mono_byte = cfg.mono_invert ? ~acc_set[23:16] : acc_set[23:16];
    end

    // Candidate results in stream order.
    always_comb begin
        cand[0] = '{out_byte: cfg.color_mode ? CMD_COLOR : CMD_MONO, byte_kind: KIND_CMD};
        cand[1] = '{out_byte: lc_cur + 8'd1, byte_kind: KIND_ADDR};
        cand[2] = '{out_byte: cfg.color_mode ? swapped[23:16] : mono_byte,
                    byte_kind: KIND_DATA};
        cand[3] = '{out_byte: swapped[15:8], byte_kind: KIND_DATA};
        cand[4] = '{out_byte: swapped[7:0], byte_kind: KIND_DATA};
        cand[5] = '{out_byte: 8'd0, byte_kind: KIND_TRAIL};
        cand[6] = '{out_byte: 8'd0, byte_kind: KIND_TRAIL};
        cand_en = {frame_end_reg, any_end, emit && cfg.color_mode, emit && cfg.color_mode,
                   emit, line_start_reg, frame_start_reg};
    end

    // Compact enabled candidates into the result list, capped at its depth.
    always_comb begin
        logic [CNT_W-1:0] n;
        n       = '0;
        lst.ent = '0;
        for (int i = 0; i < N_CAND; i++) begin
            if (cand_en[i] && (n < CNT_W'(MAX_RES))) begin
                lst.ent[n] = cand[i];
                n          = n + CNT_W'(1);
            end
        end
        lst.cnt = n;
    end

    // Next packing state.
    always_comb begin
        acc_next         = acc_reg;
        bc_next          = bc_reg;
        lc_next          = lc_reg;
        line_start_next  = line_start_reg;
        frame_start_next = frame_start_reg;
        if (advance) begin
            acc_next         = emit ? 24'd0 : acc_set;
            bc_next          = emit ? 5'd0 : bc_inc;
            lc_next          = any_end ? lc_cur + 8'd1 : lc_cur;
            line_start_next  = any_end;
            frame_start_next = frame_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg         <= 24'd0;
            bc_reg          <= 5'd0;
            lc_reg          <= 8'd0;
            line_start_reg  <= 1'b1;
            frame_start_reg <= 1'b1;
        end else begin
            acc_reg         <= acc_next;
            bc_reg          <= bc_next;
            lc_reg          <= lc_next;
            line_start_reg  <= line_start_next;
            frame_start_reg <= frame_start_next;
        end
    end

endmodule

[rtl/mlp_ser.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer result serializer
// Holds the result list of one item and sends its bytes out, entry 0 first.
// ----------------------------------------------------------------------------
module mlp_ser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               list_vld,
    input  mlp_pkg::res_list_t list,
    output logic               ser_ready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,   // [7:0] out_byte
    output logic               m_tlast,   // last
    output logic [1:0]         m_tuser    // [1:0] byte_kind
);
    import mlp_pkg::*;

    res_t [MAX_RES-1:0] ent_reg, ent_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               m_fire;

    assign m_tvalid  = cnt_reg != '0;
    assign m_fire    = m_tvalid && m_tready;
    assign m_tdata   = ent_reg[0].out_byte;
    assign m_tuser   = ent_reg[0].byte_kind;
    assign m_tlast   = cnt_reg == CNT_W'(1);
    // Free once empty, or when the final byte leaves in this cycle.
    assign ser_ready = (cnt_reg == '0) || (m_tlast && m_tready);

    // Load a new list or shift the held one by one entry.
    always_comb begin
        ent_next = ent_reg;
        cnt_next = cnt_reg;
        if (list_vld) begin
            ent_next = list.ent;
            cnt_next = list.cnt;
        end else if (m_fire) begin
            for (int i = 0; i < MAX_RES - 1; i++) begin
                ent_next[i] = ent_reg[i + 1];
            end
            ent_next[MAX_RES-1] = '0;
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

[rtl/memory_lcd_line_packer_top.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer top level
// Packs 8-bit samples into the byte stream of a memory-LCD multi-line write.
// ----------------------------------------------------------------------------
// Usage:
//   Samples enter on the s_ channel, one per item: s_tdata is the gray pixel
//   (mono) or subpixel level (colour), s_tlast marks a line end and s_tuser a
//   frame end. Bytes leave on the m_ channel: m_tdata is the byte, m_tuser
//   its kind (command, line address, pixel data, trailer), and m_tlast marks
//   the final byte caused by one input item.
//   Registers on the APB-style port are to be written by the user only
//   while the block is idle; the block itself does not enforce this. An
//   item waits in the input register until its result list is loaded into
//   the serializer. Throughput: while the receiver is ready, one item per
//   cycle for items causing at most one byte each; a longer list holds the
//   input, as the serializer sends one byte per cycle from its result list.
//   Reset empties both stages and starts a new frame and line.
//   When the receiver stalls, the result list waits, the held item waits
//   behind it, and s_tready falls once both are full.
// ----------------------------------------------------------------------------
module memory_lcd_line_packer_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Input samples
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tlast,   // line_end
    input  logic        s_tuser,   // [0] frame_end
    // Output bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // last
    output logic [1:0]  m_tuser,   // [1:0] byte_kind
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mlp_pkg::*;

    cfg_t      cfg;
    res_list_t list;
    logic      list_vld;
    logic      ser_ready;

    // Configuration registers.
    mlp_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register and bit packing.
    mlp_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .ser_ready (ser_ready),
        .list_vld  (list_vld),
        .list      (list)
    );

    // Result list and output serializer.
    mlp_ser u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .list_vld  (list_vld),
        .list      (list),
        .ser_ready (ser_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/mlp_checker.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer port checker
// Watches the result channel of the top level and flags broken sequences.
// ----------------------------------------------------------------------------
`include "memory_lcd_line_packer_top_defines.svh"

module mlp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic [1:0] m_tuser
);
    import mlp_pkg::*;

    // A stalled byte keeps its value.
    `MLP_ASSERT(a_hold, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)), "stalled byte changed")

    // The result channel is empty right after reset.
    `MLP_ASSERT_ALWAYS(a_reset_empty, (!aresetn |=> !m_tvalid), "result valid after reset")

    // A command byte is never marked last; a line address of the same item follows.
    `MLP_ASSERT(a_cmd_not_last, (m_tvalid && (m_tuser == KIND_CMD) |-> !m_tlast), "command ended an item")

    // Trailer bytes are zero.
    `MLP_ASSERT(a_trail_zero, (m_tvalid && (m_tuser == KIND_TRAIL) |-> (m_tdata == 8'd0)), "nonzero trailer")

endmodule

bind memory_lcd_line_packer_top mlp_checker u_mlp_checker (.*);

[dv/mlp_stream_checker.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer stream checker
// Watches the sample, byte and register ports of the packer. It predicts the
// write stream that each accepted sample causes and compares every accepted
// byte, field by field, against the oldest predicted byte.
// ----------------------------------------------------------------------------
module mlp_stream_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] sample
    input  logic        s_tlast,   // line_end
    input  logic        s_tuser,   // [0] frame_end
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_byte
    input  logic        m_tlast,   // last
    input  logic [1:0]  m_tuser,   // [1:0] byte_kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          bytes_pending
);
    import mlp_pkg::*;

    // Bit positions of the three colors inside each 3-bit group.
    localparam logic [23:0] LOW_BITS  = 24'h249249;
    localparam logic [23:0] MID_BITS  = 24'h492492;
    localparam logic [23:0] HIGH_BITS = 24'h924924;

    typedef struct {
        logic [7:0] value;
        logic [1:0] kind;
        logic       is_last;
    } stream_byte_t;

    // Register copies, as seen on the configuration port.
    logic       cfg_color;
    logic [7:0] cfg_mono_cut;
    logic [7:0] cfg_color_cut;
    logic       cfg_invert;
    logic [7:0] cfg_start_line;

    // Packer state.
    logic [23:0] acc;
    logic [4:0]  bit_cnt;
    logic [7:0]  line_cnt;
    logic        at_line_start;
    logic        at_frame_start;

    // Bytes of the sample being packed, and the stream still to arrive.
    stream_byte_t item_bytes[$];
    stream_byte_t expected_bytes[$];

    initial fail_count = 0;
    initial bytes_pending = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    // Emit the accumulated group: one byte in mono, three swapped bytes in color.
    task automatic flush_group();
        logic [23:0] d;
        logic [7:0]  b;
        d = acc;
        if (cfg_color) begin
            d = ((d >> 2) & LOW_BITS) | (d & MID_BITS) | ((d << 2) & HIGH_BITS);
            item_bytes.push_back('{d[23:16], KIND_DATA, 1'b0});
            item_bytes.push_back('{d[15:8], KIND_DATA, 1'b0});
            item_bytes.push_back('{d[7:0], KIND_DATA, 1'b0});
        end else begin
            b = d[23:16];
            if (cfg_invert) begin
                b = ~b;
            end
            item_bytes.push_back('{b, KIND_DATA, 1'b0});
        end
        acc = '0;
        bit_cnt = '0;
    endtask

    // Work out the bytes that one sample causes and queue them.
    task automatic pack_sample(input logic [7:0] smp, input logic ends_line,
                               input logic ends_frame);
        logic [4:0] group_bits;
        logic [7:0] cut;
        int         n;
        stream_byte_t e;
        item_bytes.delete();
        group_bits = cfg_color ? GROUP_COLOR : GROUP_MONO;
        cut = cfg_color ? cfg_color_cut : cfg_mono_cut;

        if (at_frame_start) begin
            item_bytes.push_back('{cfg_color ? CMD_COLOR : CMD_MONO, KIND_CMD, 1'b0});
            line_cnt = cfg_start_line;
            at_frame_start = 1'b0;
        end
        if (at_line_start) begin
            item_bytes.push_back('{line_cnt + 8'd1, KIND_ADDR, 1'b0});
            at_line_start = 1'b0;
        end

        // A mode switch mid-group can leave more bits than mono uses.
        if (bit_cnt > BIT_MAX) begin
            bit_cnt = BIT_MAX;
        end
        if (smp >= cut) begin
            acc[BIT_MAX - bit_cnt] = 1'b1;
        end
        bit_cnt++;
        if (bit_cnt >= group_bits) begin
            flush_group();
        end

        // A frame end closes the line as well.
        if (ends_line || ends_frame) begin
            if (bit_cnt != 0) begin
                flush_group();
            end
            item_bytes.push_back('{8'd0, KIND_TRAIL, 1'b0});
            line_cnt++;
            at_line_start = 1'b1;
        end
        if (ends_frame) begin
            item_bytes.push_back('{8'd0, KIND_TRAIL, 1'b0});
            at_frame_start = 1'b1;
        end

        // Bytes past the cap are dropped; the last kept one carries tlast.
        n = (item_bytes.size() > MAX_RES) ? MAX_RES : item_bytes.size();
        for (int i = 0; i < n; i++) begin
            e = item_bytes[i];
            e.is_last = (i == n - 1);
            expected_bytes.push_back(e);
        end
    endtask

    // Track registers, check bytes, then predict; a byte leaving now can never
    // belong to a sample taken at the same edge.
    always @(posedge aclk) begin
        stream_byte_t want;
        if (!aresetn) begin
            cfg_color      = 1'b0;
            cfg_mono_cut   = 8'd128;
            cfg_color_cut  = 8'd128;
            cfg_invert     = 1'b0;
            cfg_start_line = 8'd0;
            acc            = '0;
            bit_cnt        = '0;
            line_cnt       = 8'd0;
            at_line_start  = 1'b1;
            at_frame_start = 1'b1;
            expected_bytes.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[4:2])
                    REG_COLOR_MODE:   cfg_color      = pwdata[0];
                    REG_MONO_CUTOFF:  cfg_mono_cut   = pwdata[7:0];
                    REG_COLOR_CUTOFF: cfg_color_cut  = pwdata[7:0];
                    REG_MONO_INVERT:  cfg_invert     = pwdata[0];
                    REG_START_LINE:   cfg_start_line = pwdata[7:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("byte %02h kind %0d with nothing expected",
                                              m_tdata, m_tuser));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.value) begin
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  m_tdata, want.value));
                    end
                    if (m_tuser !== want.kind) begin
                        report_mismatch($sformatf("byte_kind %0d, expected %0d",
                                                  m_tuser, want.kind));
                    end
                    if (m_tlast !== want.is_last) begin
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  m_tlast, want.is_last));
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                pack_sample(s_tdata, s_tlast, s_tuser);
            end
        end
        bytes_pending = expected_bytes.size();
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Memory-LCD line packer testbench
// Drives samples and register writes into the packer, with random pauses on
// both channels, and leaves prediction and checking to the stream checker.
// A short directed part covers field extremes and the corner cases, then
// random frames run under a series of register settings.
// ----------------------------------------------------------------------------
module testbench;
    import mlp_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int RANDOM_ITEMS = 280;
    localparam int CALM_ITEMS   = 30;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] sample
    logic        s_tlast = 1'b0; // line_end
    logic        s_tuser = 1'b0; // [0] frame_end
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;        // [7:0] out_byte
    logic        m_tlast;        // last
    logic [1:0]  m_tuser;        // [1:0] byte_kind
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int bytes_pending;

    // Pauses on both channels, and the settings the samples are aimed at.
    bit         pauses_on = 1'b1;
    logic       cur_color = 1'b0;
    logic [7:0] cur_mono_cut = 8'd128;
    logic [7:0] cur_color_cut = 8'd128;

    memory_lcd_line_packer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    mlp_stream_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .bytes_pending (bytes_pending)
    );

    // Clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: stalls in short bursts while pauses are on.
    initial begin
        forever begin
            @(negedge aclk);
            if (pauses_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    // Give up after a generous time.
    initial begin
        #(8 * LIMIT_CYCLES);
        $display("** memory_lcd_line_packer_top: FAILED **");
        $finish;
    end

    // Register write: setup then access phase, with the bus quiet before the task returns.
    task automatic write_reg(input logic [REG_AW-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one item, with an optional gap first; returns at a falling edge.
    task automatic send_sample(input logic [7:0] smp, input logic ends_line,
                               input logic ends_frame);
        if (pauses_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= ends_line;
        s_tuser  <= ends_frame;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Let the stream drain, then keep waiting for items that cause no byte.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (bytes_pending != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 3))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Samples cluster around the active cutoff.
    function automatic logic [7:0] rand_sample();
        logic [7:0] cut;
        cut = cur_color ? cur_color_cut : cur_mono_cut;
        case ($urandom_range(0, 3))
            0:       return cut;
            1:       return cut - 8'd1;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // New values for every register.
    task automatic new_settings();
        logic       invert;
        logic [7:0] start;
        cur_color     = 1'($urandom_range(0, 1));
        cur_mono_cut  = pick_level();
        cur_color_cut = pick_level();
        invert        = 1'($urandom_range(0, 1));
        start         = pick_level();
        write_reg(REG_COLOR_MODE, {31'd0, cur_color});
        write_reg(REG_MONO_CUTOFF, {24'd0, cur_mono_cut});
        write_reg(REG_COLOR_CUTOFF, {24'd0, cur_color_cut});
        write_reg(REG_MONO_INVERT, {31'd0, invert});
        write_reg(REG_START_LINE, {24'd0, start});
    endtask

    // Mostly well-formed frames of a few lines, with some stray flagged items.
    task automatic random_phase(input int count);
        int left;
        int lines;
        int line_len;
        int group_len;
        int l;
        int k;
        logic ends_line;
        logic ends_frame;
        left = count;
        group_len = cur_color ? 24 : 8;
        while (left > 0) begin
            if ($urandom_range(0, 7) == 0) begin
                send_sample(rand_sample(), $urandom_range(0, 3) == 0,
                            $urandom_range(0, 7) == 0);
                left--;
            end else begin
                lines = $urandom_range(1, 3);
                for (l = 0; l < lines && left > 0; l++) begin
                    case ($urandom_range(0, 3))
                        0:       line_len = group_len;
                        1:       line_len = 1;
                        default: line_len = $urandom_range(1, group_len + 3);
                    endcase
                    for (k = 0; k < line_len && left > 0; k++) begin
                        ends_frame = (k == line_len - 1) && (l == lines - 1);
                        ends_line  = (k == line_len - 1) &&
                                     (l != lines - 1 || $urandom_range(0, 1) == 1);
                        send_sample(rand_sample(), ends_line, ends_frame);
                        left--;
                    end
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        logic [7:0] mono_line[8];
        int random_left;
        int n;
        mono_line = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd1, 8'd254, 8'd128, 8'd0};

        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: one full mono line around the cutoff, then a frame
        // that ends without a line end on a partial byte.
        for (int i = 0; i < 8; i++) begin
            send_sample(mono_line[i], i == 7, 1'b0);
        end
        send_sample(8'd200, 1'b0, 1'b0);
        send_sample(8'd50, 1'b0, 1'b0);
        send_sample(8'd128, 1'b0, 1'b1);

        // Color with every bit set, first line at the top index so the line
        // address wraps; a one-sample line exceeds the byte cap.
        wait_idle();
        cur_color = 1'b1;
        cur_color_cut = 8'd0;
        write_reg(REG_COLOR_MODE, 32'd1);
        write_reg(REG_COLOR_CUTOFF, 32'd0);
        write_reg(REG_START_LINE, 32'd255);
        send_sample(8'd0, 1'b1, 1'b1);
        send_sample(8'd255, 1'b1, 1'b0);
        send_sample(8'd17, 1'b0, 1'b1);
        // Leave a partial color group behind for the mode switch.
        for (int i = 0; i < 5; i++) begin
            send_sample(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end

        // Switch to inverted mono mid-group with the highest cutoff.
        wait_idle();
        cur_color = 1'b0;
        cur_mono_cut = 8'd255;
        write_reg(REG_COLOR_MODE, 32'd0);
        write_reg(REG_MONO_INVERT, 32'd1);
        write_reg(REG_MONO_CUTOFF, 32'd255);
        send_sample(8'd255, 1'b0, 1'b0);
        send_sample(8'd0, 1'b0, 1'b0);
        send_sample(8'd254, 1'b0, 1'b0);
        send_sample(8'd255, 1'b1, 1'b1);

        // Random frames under changing settings.
        random_left = RANDOM_ITEMS;
        while (random_left > CALM_ITEMS) begin
            n = $urandom_range(35, 50);
            if (n > random_left - CALM_ITEMS) begin
                n = random_left - CALM_ITEMS;
            end
            wait_idle();
            new_settings();
            pauses_on = ($urandom_range(0, 2) != 0);
            random_phase(n);
            random_left -= n;
        end

        // Last stretch runs with no pauses.
        wait_idle();
        new_settings();
        pauses_on = 1'b0;
        random_phase(random_left);

        s_tvalid <= 1'b0;
        while (bytes_pending != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        if (fail_count == 0) begin
            $display("** memory_lcd_line_packer_top: PASSED **");
        end else begin
            $display("** memory_lcd_line_packer_top: FAILED **");
        end
        $finish;
    end

endmodule
